/* rtl/core/ppbp_pkg.sv */
// ----------------------------------------------------------------------------
// ppbp_pkg
// shared constants for the path perceptron branch predictor
// ----------------------------------------------------------------------------
package ppbp_pkg;

    // branch address width
    localparam int ADDR_W = 32;

    // limit register width
    localparam int LIMIT_W = 8;

    // operation codes
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;

    // configuration register indexes
    localparam logic CFG_UPPER_LIMIT = 1'b0;
    localparam logic CFG_LOWER_LIMIT = 1'b1;

    // limit reset values
    localparam logic signed [LIMIT_W-1:0] UPPER_LIMIT_RST = 8'sd126;
    localparam logic signed [LIMIT_W-1:0] LOWER_LIMIT_RST = -8'sd127;

endpackage

/* rtl/core/ppbp_ram.sv */
// ----------------------------------------------------------------------------
// ppbp_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module ppbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/ppbp_modc.sv */
// ----------------------------------------------------------------------------
// ppbp_modc
// remainder of an address by a constant, reciprocal multiply with one
// correction step, three register stages
// ----------------------------------------------------------------------------
module ppbp_modc #(
    parameter int DIVISOR = 16,
    localparam int REM_W = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
    input  logic                        clk,
    input  logic [ppbp_pkg::ADDR_W-1:0] value,
    output logic [REM_W-1:0]            rem
);

    localparam int W = ppbp_pkg::ADDR_W;
    localparam longint unsigned RECIP_WIDE = (64'd1 << W) / DIVISOR;
    localparam logic [W-1:0] RECIP =
        (RECIP_WIDE > {32'd0, {W{1'b1}}}) ? {W{1'b1}} : W'(RECIP_WIDE);
    localparam logic [W-1:0] DIV_C = W'(DIVISOR);

    logic [W-1:0]     val1_reg;
    logic [2*W-1:0]   prod_reg;
    logic [W-1:0]     val2_reg;
    logic [W-1:0]     qt_reg;
    logic [REM_W-1:0] rem_reg;

    logic [2*W-1:0]   prod_next;
    logic [W-1:0]     qt_next;
    logic [W-1:0]     diff;
    logic [REM_W-1:0] rem_next;

    always_comb
    begin
        prod_next = (2*W)'(value) * (2*W)'(RECIP);
        qt_next   = prod_reg[2*W-1:W] * DIV_C;
        diff      = val2_reg - qt_reg;
        rem_next  = (diff >= DIV_C) ? REM_W'(diff - DIV_C) : REM_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        val1_reg <= value;
        prod_reg <= prod_next;
        val2_reg <= val1_reg;
        qt_reg   <= qt_next;
        rem_reg  <= rem_next;
    end

    assign rem = rem_reg;

endmodule

/* rtl/core/path_perceptron_branch_predictor_top.sv */
// ----------------------------------------------------------------------------
// path_perceptron_branch_predictor_top
// perceptron branch predictor with path history, weights in one ram
// flow: an item passes S_CALC (row and bucket remainders), then S_RUN for
//   predict and training update, then S_FIN; other updates skip S_RUN
// in_stall is high until the item leaves S_FIN; in S_RUN one weight ram
//   access per history position plus bias, streamed on read and write ports
// reset: a clearing pass zeroes the weight ram, one entry per cycle, all
//   TABLE_ROWS * (ADDRESS_BUCKETS + 1) * (HISTORY_LEN + 1) entries (18496)
// ----------------------------------------------------------------------------
module path_perceptron_branch_predictor_top #(
    parameter int TABLE_ROWS      = 64,
    parameter int ADDRESS_BUCKETS = 16,
    parameter int HISTORY_LEN     = 16,
    parameter int WEIGHT_BITS     = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         operation,
    input  logic [ppbp_pkg::ADDR_W-1:0]  branch_address,
    input  logic                         outcome_taken,
    input  logic                         squash,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         predicted_taken,
    output logic                         trained,
    input  logic                         cfg_write,
    input  logic                         cfg_index,
    input  logic [ppbp_pkg::LIMIT_W-1:0] cfg_data
);

    localparam int PLANE_SIZE = HISTORY_LEN + 1;
    localparam int ROW_SIZE   = (ADDRESS_BUCKETS + 1) * PLANE_SIZE;
    localparam int DEPTH      = TABLE_ROWS * ROW_SIZE;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W      = (TABLE_ROWS > 1) ? $clog2(TABLE_ROWS) : 1;
    localparam int BKT_W      = (ADDRESS_BUCKETS > 1) ? $clog2(ADDRESS_BUCKETS) : 1;
    localparam int POS_W      = $clog2(HISTORY_LEN + 1);
    localparam int HIDX_W     = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int SUM_W      = WEIGHT_BITS + $clog2(HISTORY_LEN + 2) + 1;
    localparam int CMP_W      = ((WEIGHT_BITS > ppbp_pkg::LIMIT_W) ?
                                 WEIGHT_BITS : ppbp_pkg::LIMIT_W) + 1;

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    // work kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_PRED   = 3'd1;
    localparam logic [2:0] KIND_TRAIN  = 3'd2;
    localparam logic [2:0] KIND_SQUASH = 3'd3;
    localparam logic [2:0] KIND_COMMIT = 3'd4;

    localparam logic [2:0] CALC_LAST = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [2:0]             kind_reg, kind_next;
    logic [2:0]             calc_cnt_reg, calc_cnt_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   term_valid_reg, term_valid_next;
    logic                   pending_reg;
    logic                   out_valid_reg, out_valid_next;

    logic                   op_reg;
    logic [ppbp_pkg::ADDR_W-1:0] addr_reg;
    logic                   taken_reg;
    logic                   squash_reg;
    logic [AW-1:0]          base_reg;
    logic [BKT_W-1:0]       bucket_reg;
    logic                   term_dir_reg;
    logic [AW-1:0]          wr_addr_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic                   pred_out_reg;
    logic                   trained_out_reg;

    logic signed [ppbp_pkg::LIMIT_W-1:0] upper_reg;
    logic signed [ppbp_pkg::LIMIT_W-1:0] lower_reg;

    logic [BKT_W-1:0]       spec_bkt_reg   [HISTORY_LEN];
    logic                   spec_out_reg   [HISTORY_LEN];
    logic [BKT_W-1:0]       commit_bkt_reg [HISTORY_LEN];
    logic                   commit_out_reg [HISTORY_LEN];

    logic [ROW_W-1:0]       row_rem;
    logic [BKT_W-1:0]       bkt_rem;

    logic                   is_pred;
    logic [HIDX_W-1:0]      hidx;
    logic [BKT_W-1:0]       hist_bkt;
    logic                   hist_out;
    logic [AW-1:0]          rd_addr;
    logic                   dir_now;
    logic [WEIGHT_BITS-1:0] rd_data;
    logic signed [WEIGHT_BITS-1:0] w_s;
    logic signed [CMP_W-1:0] w_x;
    logic signed [CMP_W-1:0] upper_x;
    logic signed [CMP_W-1:0] lower_x;
    logic signed [WEIGHT_BITS-1:0] w_new;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WEIGHT_BITS-1:0] ram_wdata;
    logic                   out_free;
    logic                   fin_fire;
    logic                   accept;
    logic                   pred_now;

    ppbp_modc #(.DIVISOR(TABLE_ROWS)) u_row_mod (
        .clk   (clk),
        .value (addr_reg),
        .rem   (row_rem)
    );

    ppbp_modc #(.DIVISOR(ADDRESS_BUCKETS)) u_bkt_mod (
        .clk   (clk),
        .value (addr_reg),
        .rem   (bkt_rem)
    );

    ppbp_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // address generation
    always_comb
    begin
        is_pred  = (op_reg == ppbp_pkg::OP_PREDICT);
        hidx     = HIDX_W'(pos_reg - POS_W'(1));
        hist_bkt = is_pred ? spec_bkt_reg[hidx] : commit_bkt_reg[hidx];
        hist_out = is_pred ? spec_out_reg[hidx] : commit_out_reg[hidx];
        if (pos_reg == '0)
        begin
            rd_addr = base_reg;
            dir_now = is_pred ? 1'b1 : taken_reg;
        end
        else
        begin
            rd_addr = base_reg
                    + AW'(({1'b0, hist_bkt} + 1'b1) * PLANE_SIZE)
                    + AW'(pos_reg);
            dir_now = is_pred ? hist_out : (hist_out == taken_reg);
        end
    end

    // weight training step
    always_comb
    begin
        w_s     = signed'(rd_data);
        w_x     = CMP_W'(w_s);
        upper_x = CMP_W'(upper_reg);
        lower_x = CMP_W'(lower_reg);
        w_new   = w_s;
        if (term_dir_reg)
        begin
            if (w_x <= upper_x && w_s != W_MAX)
            begin
                w_new = w_s + 1'b1;
            end
        end
        else
        begin
            if (w_x >= lower_x && w_s != W_MIN)
            begin
                w_new = w_s - 1'b1;
            end
        end
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = term_valid_reg && (kind_reg == KIND_TRAIN);
            ram_waddr = wr_addr_reg;
            ram_wdata = w_new;
        end
    end

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign fin_fire = (state_reg == S_FIN) && !term_valid_reg && out_free;
    assign pred_now = !acc_reg[SUM_W-1];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        calc_cnt_next   = calc_cnt_reg;
        pos_next        = pos_reg;
        clr_next        = clr_reg;
        term_valid_next = (state_reg == S_RUN);
        out_valid_next  = out_valid_reg && out_stall;
        if (fin_fire)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = S_CALC;
                    calc_cnt_next = '0;
                end
            end
            S_CALC:
            begin
                calc_cnt_next = calc_cnt_reg + 1'b1;
                if (calc_cnt_reg == CALC_LAST)
                begin
                    pos_next = '0;
                    priority if (is_pred)
                    begin
                        kind_next  = KIND_PRED;
                        state_next = S_RUN;
                    end
                    else if (squash_reg)
                    begin
                        kind_next  = KIND_SQUASH;
                        state_next = S_FIN;
                    end
                    else if (!pending_reg)
                    begin
                        kind_next  = KIND_NONE;
                        state_next = S_FIN;
                    end
                    else if (spec_out_reg[0] != taken_reg)
                    begin
                        kind_next  = KIND_TRAIN;
                        state_next = S_RUN;
                    end
                    else
                    begin
                        kind_next  = KIND_COMMIT;
                        state_next = S_FIN;
                    end
                end
            end
            S_RUN:
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg == POS_W'(HISTORY_LEN))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            kind_reg       <= KIND_NONE;
            calc_cnt_reg   <= '0;
            pos_reg        <= '0;
            clr_reg        <= '0;
            term_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            calc_cnt_reg   <= calc_cnt_next;
            pos_reg        <= pos_next;
            clr_reg        <= clr_next;
            term_valid_reg <= term_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // item payload and datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= operation;
            addr_reg   <= branch_address;
            taken_reg  <= outcome_taken;
            squash_reg <= squash;
        end
        if (state_reg == S_CALC && calc_cnt_reg == CALC_LAST - 3'd1)
        begin
            base_reg   <= AW'(row_rem * ROW_SIZE);
            bucket_reg <= bkt_rem;
        end
        if (state_reg == S_CALC)
        begin
            acc_reg <= '0;
        end
        else if (term_valid_reg && kind_reg == KIND_PRED)
        begin
            acc_reg <= term_dir_reg ? acc_reg + SUM_W'(w_s) : acc_reg - SUM_W'(w_s);
        end
        if (state_reg == S_RUN)
        begin
            wr_addr_reg  <= rd_addr;
            term_dir_reg <= dir_now;
        end
        if (fin_fire)
        begin
            pred_out_reg    <= (kind_reg == KIND_PRED) && pred_now;
            trained_out_reg <= (kind_reg == KIND_TRAIN);
        end
    end

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= ppbp_pkg::UPPER_LIMIT_RST;
            lower_reg <= ppbp_pkg::LOWER_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ppbp_pkg::CFG_UPPER_LIMIT: upper_reg <= signed'(cfg_data);
                ppbp_pkg::CFG_LOWER_LIMIT: lower_reg <= signed'(cfg_data);
                default: ;
            endcase
        end
    end

    // path histories and pending flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
            for (int i = 0; i < HISTORY_LEN; i++)
            begin
                spec_bkt_reg[i]   <= '0;
                spec_out_reg[i]   <= 1'b0;
                commit_bkt_reg[i] <= '0;
                commit_out_reg[i] <= 1'b0;
            end
        end
        else if (fin_fire)
        begin
            unique case (kind_reg)
                KIND_PRED:
                begin
                    pending_reg <= 1'b1;
                    for (int i = HISTORY_LEN - 1; i > 0; i--)
                    begin
                        spec_bkt_reg[i] <= spec_bkt_reg[i-1];
                        spec_out_reg[i] <= spec_out_reg[i-1];
                    end
                    spec_bkt_reg[0] <= bucket_reg;
                    spec_out_reg[0] <= pred_now;
                end
                KIND_TRAIN:
                begin
                    pending_reg     <= 1'b0;
                    spec_out_reg[0] <= taken_reg;
                    for (int i = HISTORY_LEN - 1; i > 0; i--)
                    begin
                        commit_bkt_reg[i] <= commit_bkt_reg[i-1];
                        commit_out_reg[i] <= commit_out_reg[i-1];
                    end
                    commit_bkt_reg[0] <= bucket_reg;
                    commit_out_reg[0] <= taken_reg;
                end
                KIND_SQUASH:
                begin
                    pending_reg <= 1'b0;
                    for (int i = 0; i < HISTORY_LEN; i++)
                    begin
                        spec_bkt_reg[i] <= commit_bkt_reg[i];
                        spec_out_reg[i] <= commit_out_reg[i];
                    end
                end
                KIND_COMMIT:
                begin
                    pending_reg <= 1'b0;
                    for (int i = 0; i < HISTORY_LEN; i++)
                    begin
                        commit_bkt_reg[i] <= spec_bkt_reg[i];
                        commit_out_reg[i] <= spec_out_reg[i];
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign predicted_taken = pred_out_reg;
    assign trained         = trained_out_reg;

endmodule
